// File: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked on every edge, reset included
`define ASSERT_CLK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/tmrc_pkg.sv
// shared constants, types and sequencer states of the tile map collision unit
package tmrc_pkg;

  localparam int IDX_W       = 11;
  localparam int STORE_DEPTH = 2048;
  localparam int COLOR_W     = 8;
  localparam int POS_W       = 24;
  localparam int SIZE_W      = 23;
  localparam int FRAC_W      = 8;
  localparam int PIX_W       = 16;
  localparam int MULB_W      = PIX_W + 2;

  localparam int DEF_MAP_WIDTH   = 64;
  localparam int DEF_MAP_HEIGHT  = 32;
  localparam int DEF_TILE_PIXELS = 16;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV_X0,
    ST_DIV_X1,
    ST_DIV_Y0,
    ST_DIV_Y1,
    ST_ROW,
    ST_SPAN,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [PIX_W-1:0] a;
    logic             by_width;
  } mul_req_t;

endpackage

// File: rtl/tmrc_in_if.sv
// input channel: load and query words
interface tmrc_in_if;
  import tmrc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [IDX_W-1:0]         tile_index;
  logic [COLOR_W-1:0]       color_red;
  logic [COLOR_W-1:0]       color_green;
  logic [COLOR_W-1:0]       color_blue;
  logic signed [POS_W-1:0]  rect_x;
  logic signed [POS_W-1:0]  rect_y;
  logic [SIZE_W-1:0]        rect_width;
  logic [SIZE_W-1:0]        rect_height;

  modport source (
    output valid, kind, tile_index, color_red, color_green, color_blue,
           rect_x, rect_y, rect_width, rect_height,
    input  ready
  );

  modport sink (
    input  valid, kind, tile_index, color_red, color_green, color_blue,
           rect_x, rect_y, rect_width, rect_height,
    output ready
  );
endinterface

// File: rtl/tmrc_out_if.sv
// result channel: one collision flag per word
interface tmrc_out_if;
  logic valid;
  logic ready;
  logic collides;

  modport source (output valid, collides, input ready);
  modport sink (input valid, collides, output ready);
endinterface

// File: rtl/tile_map_rect_collision_unit.sv
// top level: wall map store and the query sequencer
// A load word writes one wall bit (wall when red, green and blue are all zero) and
// returns collides = 0 in the next cycle. A query word turns the rectangle into a
// tile span on one shared multiplier (four divisions by the tile size and one
// row-base product), then reads the wall map one tile per cycle, row by row, and
// stops at the first wall; its result is issued from state DONE once the output is
// free, and the next word is taken only after that. An empty span skips the walk.
// The wall map read port sets the walk rate. After reset the block runs a clearing
// pass over all 2048 store entries that marks every tile a wall and accepts no word
// meanwhile.
`include "assert_macros.svh"

module tile_map_rect_collision_unit #(
  parameter int MAP_WIDTH   = tmrc_pkg::DEF_MAP_WIDTH,
  parameter int MAP_HEIGHT  = tmrc_pkg::DEF_MAP_HEIGHT,
  parameter int TILE_PIXELS = tmrc_pkg::DEF_TILE_PIXELS
) (
  input  logic        clk,
  input  logic        rst_n,
  tmrc_in_if.sink     in_ch,
  tmrc_out_if.source  out_ch
);
  import tmrc_pkg::*;

  localparam int CW = (MAP_WIDTH > 1) ? $clog2(MAP_WIDTH) : 1;
  localparam int RW = (MAP_HEIGHT > 1) ? $clog2(MAP_HEIGHT) : 1;
  localparam logic [PIX_W-1:0] LAST_COL_P = PIX_W'(MAP_WIDTH - 1);
  localparam logic [PIX_W-1:0] LAST_ROW_P = PIX_W'(MAP_HEIGHT - 1);
  localparam logic [CW-1:0]    LAST_COL   = CW'(MAP_WIDTH - 1);
  localparam logic [RW-1:0]    LAST_ROW   = RW'(MAP_HEIGHT - 1);
  localparam logic [IDX_W-1:0] ROW_STEP   = IDX_W'(MAP_WIDTH);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(STORE_DEPTH - 1);

  state_t state_r, state_nxt;

  logic [IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_col_r, out_col_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic             rd_last_r, rd_last_nxt;
  logic             res_r, res_nxt;

  // pixel operands and positivity of the far edges
  logic [PIX_W-1:0] px0_r, px0_nxt, px1_r, px1_nxt;
  logic [PIX_W-1:0] py0_r, py0_nxt, py1_r, py1_nxt;
  logic             ex_pos_r, ex_pos_nxt, ey_pos_r, ey_pos_nxt;

  logic [PIX_W-1:0] x0_r, x0_nxt, y0_r, y0_nxt;
  logic [CW-1:0]    x1_r, x1_nxt, tx_r, tx_nxt;
  logic [RW-1:0]    y1_r, y1_nxt, ty_r, ty_nxt;
  logic [IDX_W-1:0] row_r, row_nxt;

  logic signed [POS_W:0] ex_m1, ey_m1;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic             ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic             ram_rdata;

  mul_req_t         mul_req;
  logic [PIX_W-1:0] mul_quot;
  logic [IDX_W-1:0] mul_low;

  logic in_take;
  logic out_free;
  logic empty;
  logic last_tile;

  tmrc_ram #(
    .WIDTH (1),
    .DEPTH (STORE_DEPTH)
  ) u_wall_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tmrc_mul #(
    .MAP_WIDTH   (MAP_WIDTH),
    .TILE_PIXELS (TILE_PIXELS)
  ) u_mul (
    .clk  (clk),
    .req  (mul_req),
    .quot (mul_quot),
    .low  (mul_low)
  );

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE) && out_free;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.collides = out_col_r;

  // far edge minus one lsb: its tile is the last one overlapped strictly
  always_comb begin
    ex_m1 = {in_ch.rect_x[POS_W-1], in_ch.rect_x} + {2'b00, in_ch.rect_width}
            - (POS_W+1)'(1);
    ey_m1 = {in_ch.rect_y[POS_W-1], in_ch.rect_y} + {2'b00, in_ch.rect_height}
            - (POS_W+1)'(1);
  end

  assign empty = !ex_pos_r || !ey_pos_r ||
                 (x0_r > PIX_W'(x1_r)) || (y0_r > PIX_W'(y1_r));
  assign last_tile = (tx_r == x1_r) && (ty_r == y1_r);
  assign ram_raddr = row_r + IDX_W'(tx_r);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_col_nxt   = out_col_r;
    rd_pend_nxt   = 1'b0;
    rd_last_nxt   = rd_last_r;
    res_nxt       = res_r;
    px0_nxt       = px0_r;
    px1_nxt       = px1_r;
    py0_nxt       = py0_r;
    py1_nxt       = py1_r;
    ex_pos_nxt    = ex_pos_r;
    ey_pos_nxt    = ey_pos_r;
    x0_nxt        = x0_r;
    x1_nxt        = x1_r;
    y0_nxt        = y0_r;
    y1_nxt        = y1_r;
    tx_nxt        = tx_r;
    ty_nxt        = ty_r;
    row_nxt       = row_r;
    ram_we        = 1'b0;
    ram_waddr     = clr_cnt_r;
    ram_wdata     = 1'b1;
    mul_req       = '0;

    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
        if (clr_cnt_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_take) begin
          if (in_ch.kind == KIND_LOAD) begin
            ram_we        = 1'b1;
            ram_waddr     = in_ch.tile_index;
            ram_wdata     = ~|{in_ch.color_red, in_ch.color_green, in_ch.color_blue};
            out_valid_nxt = 1'b1;
            out_col_nxt   = 1'b0;
          end else begin
            // negative near edges clamp to tile zero
            px0_nxt    = in_ch.rect_x[POS_W-1] ? '0 : {1'b0, in_ch.rect_x[POS_W-2:FRAC_W]};
            py0_nxt    = in_ch.rect_y[POS_W-1] ? '0 : {1'b0, in_ch.rect_y[POS_W-2:FRAC_W]};
            px1_nxt    = ex_m1[POS_W-1:FRAC_W];
            py1_nxt    = ey_m1[POS_W-1:FRAC_W];
            ex_pos_nxt = !ex_m1[POS_W];
            ey_pos_nxt = !ey_m1[POS_W];
            state_nxt  = ST_DIV_X0;
          end
        end
      end
      ST_DIV_X0: begin
        mul_req.a = px0_r;
        state_nxt = ST_DIV_X1;
      end
      ST_DIV_X1: begin
        mul_req.a = px1_r;
        x0_nxt    = mul_quot;
        state_nxt = ST_DIV_Y0;
      end
      ST_DIV_Y0: begin
        mul_req.a = py0_r;
        x1_nxt    = (mul_quot >= LAST_COL_P) ? LAST_COL : CW'(mul_quot);
        state_nxt = ST_DIV_Y1;
      end
      ST_DIV_Y1: begin
        mul_req.a = py1_r;
        y0_nxt    = mul_quot;
        state_nxt = ST_ROW;
      end
      ST_ROW: begin
        mul_req.a        = y0_r;
        mul_req.by_width = 1'b1;
        y1_nxt    = (mul_quot >= LAST_ROW_P) ? LAST_ROW : RW'(mul_quot);
        state_nxt = ST_SPAN;
      end
      ST_SPAN: begin
        row_nxt = mul_low;
        tx_nxt  = CW'(x0_r);
        ty_nxt  = RW'(y0_r);
        if (empty) begin
          res_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (rd_pend_r && ram_rdata) begin
          res_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else if (rd_pend_r && rd_last_r) begin
          res_nxt   = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          // read issued this cycle, tested next cycle
          rd_pend_nxt = 1'b1;
          rd_last_nxt = last_tile;
          if (!last_tile) begin
            if (tx_r == x1_r) begin
              tx_nxt  = CW'(x0_r);
              ty_nxt  = ty_r + RW'(1);
              row_nxt = row_r + ROW_STEP;
            end else begin
              tx_nxt = tx_r + CW'(1);
            end
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_col_r <= out_col_nxt;
    rd_last_r <= rd_last_nxt;
    res_r     <= res_nxt;
    px0_r     <= px0_nxt;
    px1_r     <= px1_nxt;
    py0_r     <= py0_nxt;
    py1_r     <= py1_nxt;
    ex_pos_r  <= ex_pos_nxt;
    ey_pos_r  <= ey_pos_nxt;
    x0_r      <= x0_nxt;
    x1_r      <= x1_nxt;
    y0_r      <= y0_nxt;
    y1_r      <= y1_nxt;
    tx_r      <= tx_nxt;
    ty_r      <= ty_nxt;
    row_r     <= row_nxt;
  end

  `ASSERT_CLK_RST(a_reset_clears,
    !rst_n |=> (state_r == ST_CLEAR) && !out_valid_r,
    "reset did not start the clearing pass")
  `ASSERT_CLK(a_no_take_in_clear,
    (state_r == ST_CLEAR) |-> !in_ch.ready,
    "word taken during clearing pass")
  `ASSERT_CLK(a_load_answers_zero,
    (in_take && (in_ch.kind == KIND_LOAD)) |=> (out_valid_r && !out_col_r),
    "load word did not return a zero result")
  `ASSERT_CLK(a_walk_in_span,
    (state_r == ST_WALK) |-> ((tx_r <= x1_r) && (ty_r <= y1_r)),
    "tile walk left the span")

endmodule

// File: rtl/tmrc_ram.sv
// generic single write port, single read port ram with registered read
module tmrc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/tmrc_mul.sv
// shared multiplier: pixel to tile division by reciprocal, and row times map width
module tmrc_mul #(
  parameter int MAP_WIDTH   = tmrc_pkg::DEF_MAP_WIDTH,
  parameter int TILE_PIXELS = tmrc_pkg::DEF_TILE_PIXELS
) (
  input  logic                         clk,
  input  tmrc_pkg::mul_req_t           req,
  output logic [tmrc_pkg::PIX_W-1:0]   quot,
  output logic [tmrc_pkg::IDX_W-1:0]   low
);
  import tmrc_pkg::*;

  localparam int PW     = PIX_W + MULB_W;
  localparam int SHIFT  = PIX_W + $clog2(TILE_PIXELS);
  // ceil(2^SHIFT / TILE_PIXELS) is exact for every 16-bit pixel count
  localparam int RECIP_INT = ((1 << SHIFT) + TILE_PIXELS - 1) / TILE_PIXELS;
  localparam logic [MULB_W-1:0] RECIP   = MULB_W'(RECIP_INT);
  localparam logic [MULB_W-1:0] WIDTH_B = MULB_W'(MAP_WIDTH);

  logic [MULB_W-1:0] b;
  logic [PW-1:0]     prod_nxt;
  logic [PW-1:0]     prod_r;

  always_comb begin
    b        = req.by_width ? WIDTH_B : RECIP;
    prod_nxt = PW'(req.a) * PW'(b);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign quot = PIX_W'(prod_r >> SHIFT);
  assign low  = prod_r[IDX_W-1:0];

endmodule

// File: tb/tb_tile_map_rect_collision_unit.sv
// testbench for the tile map rectangle collision unit: directed and random loads and queries against a predictor
module tb_tile_map_rect_collision_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tmrc_pkg::*;

  localparam int MAP_W    = DEF_MAP_WIDTH;
  localparam int MAP_H    = DEF_MAP_HEIGHT;
  localparam int TILE_PIX = DEF_TILE_PIXELS;
  localparam int TILE_FX  = TILE_PIX << FRAC_W;
  localparam int HOLD_CYCLES = 400;
  // clear pass plus, per word, the longest walk, the longest stalls and gaps, taken four times
  localparam int CYCLE_LIMIT = STORE_DEPTH + 1700 * (8 + STORE_DEPTH + 2 * HOLD_CYCLES) * 4;

  typedef struct {
    logic                    kind;
    logic [IDX_W-1:0]        tile_index;
    logic [COLOR_W-1:0]      red;
    logic [COLOR_W-1:0]      green;
    logic [COLOR_W-1:0]      blue;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [SIZE_W-1:0]       w;
    logic [SIZE_W-1:0]       h;
  } word_t;

  class collision_scoreboard;
    bit wall_bits [STORE_DEPTH];
    bit collide_q [$];
    int fail_count;

    function new();
      foreach (wall_bits[i]) wall_bits[i] = 1'b1;
      fail_count = 0;
    endfunction

    // pixel truncation and tile division both round toward zero
    function longint span_tile(longint pos);
      return (pos / 256) / TILE_PIX;
    endfunction

    function bit hits_wall(longint rx, longint ry, longint rw, longint rh);
      longint t_size, c0, c1, r0, r1, r, c;
      int addr;
      t_size = longint'(TILE_FX);
      c0 = span_tile(rx);
      r0 = span_tile(ry);
      c1 = span_tile(rx + rw);
      r1 = span_tile(ry + rh);
      if (c0 < 0) c0 = 0;
      if (r0 < 0) r0 = 0;
      if (c1 >= MAP_W) c1 = MAP_W - 1;
      if (r1 >= MAP_H) r1 = MAP_H - 1;
      for (r = r0; r <= r1; r++) begin
        for (c = c0; c <= c1; c++) begin
          addr = int'((r * MAP_W + c) & (STORE_DEPTH - 1));
          if (wall_bits[addr] && rx < (c + 1) * t_size && rx + rw > c * t_size &&
              ry < (r + 1) * t_size && ry + rh > r * t_size)
            return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_word(word_t wd);
      if (wd.kind == KIND_LOAD) begin
        wall_bits[wd.tile_index] = (wd.red == 0 && wd.green == 0 && wd.blue == 0);
        collide_q.push_back(1'b0);
      end else begin
        collide_q.push_back(hits_wall(longint'(wd.x), longint'(wd.y),
                                      longint'(wd.w), longint'(wd.h)));
      end
    endfunction

    function void check_result(logic got);
      bit want;
      if (collide_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result word: collides=%0b", got);
        return;
      end
      want = collide_q.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10)
          $display("collides mismatch: expected %0b, actual %0b", want, got);
      end
    endfunction

    function int pending();
      return collide_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  tmrc_in_if  in_ch ();
  tmrc_out_if out_ch ();

  collision_scoreboard sb = new();
  int  cycles = 0;
  int  items_sent = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  word_t taken;

  tile_map_rect_collision_unit #(
    .MAP_WIDTH   (MAP_W),
    .MAP_HEIGHT  (MAP_H),
    .TILE_PIXELS (TILE_PIX)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // results are checked before the new word is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.collides);
      if (in_ch.valid && in_ch.ready) begin
        taken.kind       = in_ch.kind;
        taken.tile_index = in_ch.tile_index;
        taken.red        = in_ch.color_red;
        taken.green      = in_ch.color_green;
        taken.blue       = in_ch.color_blue;
        taken.x          = in_ch.rect_x;
        taken.y          = in_ch.rect_y;
        taken.w          = in_ch.rect_width;
        taken.h          = in_ch.rect_height;
        sb.note_word(taken);
      end
    end
  end

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_word(input word_t wd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.kind        <= wd.kind;
    in_ch.tile_index  <= wd.tile_index;
    in_ch.color_red   <= wd.red;
    in_ch.color_green <= wd.green;
    in_ch.color_blue  <= wd.blue;
    in_ch.rect_x      <= wd.x;
    in_ch.rect_y      <= wd.y;
    in_ch.rect_width  <= wd.w;
    in_ch.rect_height <= wd.h;
    in_ch.valid       <= 1'b1;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic idle_until_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic word_t load_word(int idx, int r, int g, int b);
    word_t wd;
    wd.kind       = KIND_LOAD;
    wd.tile_index = IDX_W'(idx);
    wd.red        = COLOR_W'(r);
    wd.green      = COLOR_W'(g);
    wd.blue       = COLOR_W'(b);
    wd.x          = '0;
    wd.y          = '0;
    wd.w          = '0;
    wd.h          = '0;
    return wd;
  endfunction

  function automatic word_t query_word(int x, int y, int w, int h);
    word_t wd;
    wd.kind       = KIND_QUERY;
    wd.tile_index = '0;
    wd.red        = '0;
    wd.green      = '0;
    wd.blue       = '0;
    wd.x          = POS_W'(x);
    wd.y          = POS_W'(y);
    wd.w          = SIZE_W'(w);
    wd.h          = SIZE_W'(h);
    return wd;
  endfunction

  function automatic word_t floor_load(int idx);
    word_t wd;
    wd = load_word(idx, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255));
    if (wd.red == 0 && wd.green == 0 && wd.blue == 0) wd.blue = 8'd1;
    return wd;
  endfunction

  function automatic word_t random_word();
    word_t wd;
    wd.kind       = $urandom_range(1) ? KIND_QUERY : KIND_LOAD;
    wd.tile_index = IDX_W'($urandom);
    wd.red        = COLOR_W'($urandom);
    wd.green      = COLOR_W'($urandom);
    wd.blue       = COLOR_W'($urandom);
    wd.x          = POS_W'($urandom);
    wd.y          = POS_W'($urandom);
    wd.w          = SIZE_W'($urandom);
    wd.h          = SIZE_W'($urandom);
    if (wd.kind == KIND_LOAD) begin
      // most loads land in the corner that queries look at
      if ($urandom_range(99) < 70)
        wd.tile_index = IDX_W'($urandom_range(0, 5) * MAP_W + $urandom_range(0, 9));
      if ($urandom_range(99) < 30) begin
        wd.red   = '0;
        wd.green = '0;
        wd.blue  = '0;
      end
    end else if ($urandom_range(99) < 80) begin
      wd.x = POS_W'(int'($urandom_range(0, 12 * TILE_FX)) - 2 * TILE_FX);
      wd.y = POS_W'(int'($urandom_range(0, 8 * TILE_FX)) - 2 * TILE_FX);
      wd.w = SIZE_W'($urandom_range(0, 3 * TILE_FX));
      wd.h = SIZE_W'($urandom_range(0, 3 * TILE_FX));
      if ($urandom_range(9) == 0) wd.w = '0;
      if ($urandom_range(9) == 0) wd.h = '0;
    end
    return wd;
  endfunction

  // open a small room of floor tiles, then probe inside it and around its edges
  task automatic send_room();
    int cols, rows, col0, row0, r, c, x, y, w, h;
    cols = $urandom_range(1, 4);
    rows = $urandom_range(1, 4);
    col0 = $urandom_range(0, MAP_W - cols);
    row0 = $urandom_range(0, MAP_H - rows);
    for (r = row0; r < row0 + rows; r++)
      for (c = col0; c < col0 + cols; c++)
        send_word(floor_load(r * MAP_W + c));
    repeat (3) begin
      if ($urandom_range(2) != 0) begin
        x = col0 * TILE_FX + $urandom_range(0, cols * TILE_FX - 1);
        y = row0 * TILE_FX + $urandom_range(0, rows * TILE_FX - 1);
        w = $urandom_range(0, (col0 + cols) * TILE_FX - x);
        h = $urandom_range(0, (row0 + rows) * TILE_FX - y);
      end else begin
        x = (col0 - 1) * TILE_FX + $urandom_range(0, (cols + 1) * TILE_FX);
        y = (row0 - 1) * TILE_FX + $urandom_range(0, (rows + 1) * TILE_FX);
        w = $urandom_range(0, (cols + 2) * TILE_FX);
        h = $urandom_range(0, (rows + 2) * TILE_FX);
      end
      send_word(query_word(x, y, w, h));
    end
  endtask

  task automatic run_random(int target);
    while (items_sent < target) begin
      if ($urandom_range(99) < 25) send_room();
      else send_word(random_word());
    end
  endtask

  task automatic run_directed();
    word_t wd;
    send_word(load_word(0, 0, 0, 0));
    send_word(load_word(1, 255, 0, 0));
    send_word(load_word(2, 0, 255, 0));
    send_word(load_word(3, 0, 0, 255));
    wd = load_word(64, 255, 255, 255);
    wd.x = '1;
    wd.w = '1;
    send_word(wd);
    send_word(load_word(STORE_DEPTH - 1, 1, 1, 1));
    // inside one floor tile, then across three floor tiles
    send_word(query_word(TILE_FX + 256, 256, 8 * 256, 8 * 256));
    send_word(query_word(TILE_FX + 256, 256, 2 * TILE_FX, 8 * 256));
    send_word(query_word(256, 256, 256, 256));
    // zero width exactly on the wall's right edge touches nothing
    send_word(query_word(TILE_FX, 1024, 0, 0));
    // far left of the map: empty span
    send_word(query_word(-8388608, 0, 100, 100));
    // left of the map but truncated into column 0, right edge short of it, then reaching into it
    send_word(query_word(-2000, 1024, 1000, 256));
    send_word(query_word(-2000, 1024, 3000, 256));
    // extremes of the coordinate range: start past the map, end just short of it, whole map
    send_word(query_word(8388607, 8388607, 8388607, 8388607));
    send_word(query_word(-8388608, -8388608, 8388607, 8388607));
    wd = query_word(0, 0, 8388607, 8388607);
    wd.tile_index = '1;
    wd.red        = '1;
    send_word(wd);
    send_word(query_word(63 * TILE_FX + 100, 31 * TILE_FX + 100, 200, 200));
    send_word(load_word(STORE_DEPTH - 1, 0, 0, 0));
    send_word(query_word(63 * TILE_FX + 100, 31 * TILE_FX + 100, 200, 200));
    // end indices past the map clamp to the last column and row
    send_word(query_word(63 * TILE_FX + 100, 31 * TILE_FX, 10 * TILE_FX, 10 * TILE_FX));
  endtask

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.kind           = KIND_LOAD;
    in_ch.tile_index     = '0;
    in_ch.color_red      = '0;
    in_ch.color_green    = '0;
    in_ch.color_blue     = '0;
    in_ch.rect_x         = '0;
    in_ch.rect_y         = '0;
    in_ch.rect_width     = '0;
    in_ch.rect_height    = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(420);

    send_idle_pct = 74;
    run_random(820);

    // long receiver hold-off while words keep coming back to back
    send_idle_pct = 0;
    hold_req      = 1'b1;
    run_random(items_sent + 30);
    idle_until_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 74;
    run_random(1240);

    send_idle_pct  = 26;
    recv_stall_pct = 26;
    run_random(1670);

    idle_until_drained();
    repeat (64) @(negedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
